FILE: hw/rtl/srd_pkg.sv
// Shared types and constants of the single rectangle detector.
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

   // Largest frame size and the widths that follow from it
   localparam int MAX_ROWS = 1024;
   localparam int MAX_COLS = 1024;
   localparam int SIZE_W   = 11;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int COUNT_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
   localparam int SPAN_W   = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
   localparam int AREA_W   = 2 * SPAN_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [SIZE_W-1:0] MAX_ROWS_SIZE = SIZE_W'(MAX_ROWS);
   localparam logic [SIZE_W-1:0] MAX_COLS_SIZE = SIZE_W'(MAX_COLS);

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_COLS = CSR_IDX_W'(1);

   // Frame verdict
   typedef enum logic [1:0] {
      STATUS_NONE  = 2'd0,
      STATUS_RECT  = 2'd1,
      STATUS_OTHER = 2'd2
   } status_type;

   // Last row and column index of the current frame size
   typedef struct packed {
      logic [ROW_W-1:0] last_row;
      logic [COL_W-1:0] last_col;
   } frame_size_type;

   // Verdict of one frame
   typedef struct packed {
      status_type       status;
      logic [ROW_W-1:0] top_row;
      logic [COL_W-1:0] left_col;
      logic [ROW_W-1:0] bottom_row;
      logic [COL_W-1:0] right_col;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/srd_cfg.sv
// Frame size registers with clamping to the supported range.
`timescale 1ns / 1ps
`default_nettype none

module srd_cfg
   import srd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_wdata,
   output frame_size_type            frame_size
);

   logic [SIZE_W-1:0] rows_ff;
   logic [SIZE_W-1:0] cols_ff;
   logic [SIZE_W-1:0] rows_eff;
   logic [SIZE_W-1:0] cols_eff;

   // Take register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_W'(1);
         cols_ff <= SIZE_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_ROWS: rows_ff <= csr_wdata;
            REG_IMAGE_COLS: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp zero to one and large sizes to the maximum, then form last index
   always_comb begin
      rows_eff = rows_ff;
      if (rows_ff == '0) rows_eff = SIZE_W'(1);
      else if (rows_ff > MAX_ROWS_SIZE) rows_eff = MAX_ROWS_SIZE;
      cols_eff = cols_ff;
      if (cols_ff == '0) cols_eff = SIZE_W'(1);
      else if (cols_ff > MAX_COLS_SIZE) cols_eff = MAX_COLS_SIZE;
      frame_size.last_row = ROW_W'(rows_eff - SIZE_W'(1));
      frame_size.last_col = COL_W'(cols_eff - SIZE_W'(1));
   end

endmodule

`default_nettype wire

FILE: hw/rtl/srd_track.sv
// Raster position, bounding box and black pixel count of the current frame.
`timescale 1ns / 1ps
`default_nettype none

module srd_track
   import srd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           pixel_black,
   input  wire frame_size_type frame_size,
   output logic                frame_end,
   output result_type          result
);

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               seen_ff, seen_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [COL_W-1:0]   left_ff, left_in;
   logic [ROW_W-1:0]   bottom_ff, bottom_in;
   logic [COL_W-1:0]   right_ff, right_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               first_black;
   logic               row_end;
   logic [SPAN_W-1:0]  height;
   logic [SPAN_W-1:0]  width;
   logic [AREA_W-1:0]  area;

   // Grow the bounding box with this pixel
   always_comb begin
      first_black = pixel_black && !seen_ff;
      seen_in     = seen_ff || pixel_black;
      top_in      = first_black ? row_ff : top_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      bottom_in   = bottom_ff;
      if (first_black) begin
         left_in   = col_ff;
         right_in  = col_ff;
         bottom_in = row_ff;
      end else if (pixel_black) begin
         if (col_ff < left_ff)    left_in   = col_ff;
         if (col_ff > right_ff)   right_in  = col_ff;
         if (row_ff > bottom_ff)  bottom_in = row_ff;
      end
      count_in = count_ff + COUNT_W'(pixel_black);
   end

   // Detect the end of row and frame
   always_comb begin
      row_end   = col_ff >= frame_size.last_col;
      frame_end = row_end && (row_ff >= frame_size.last_row);
      row_in    = row_end ? row_ff + ROW_W'(1) : row_ff;
      col_in    = row_end ? '0 : col_ff + COL_W'(1);
   end

   // Solid rectangle when the box area equals the black count
   always_comb begin
      height = SPAN_W'(bottom_in) - SPAN_W'(top_in) + SPAN_W'(1);
      width  = SPAN_W'(right_in) - SPAN_W'(left_in) + SPAN_W'(1);
      area   = height * width;
      result = '0;
      if (!seen_in) begin
         result.status = STATUS_NONE;
      end else if (area == AREA_W'(count_in)) begin
         result.status     = STATUS_RECT;
         result.top_row    = top_in;
         result.left_col   = left_in;
         result.bottom_row = bottom_in;
         result.right_col  = right_in;
      end else begin
         result.status = STATUS_OTHER;
      end
   end

   // Advance on each pixel; clear everything after the last one
   always_ff @(posedge clock) begin
      if (reset || (advance && frame_end)) begin
         row_ff    <= '0;
         col_ff    <= '0;
         seen_ff   <= 1'b0;
         top_ff    <= '0;
         left_ff   <= '0;
         bottom_ff <= '0;
         right_ff  <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         seen_ff   <= seen_in;
         top_ff    <= top_in;
         left_ff   <= left_in;
         bottom_ff <= bottom_in;
         right_ff  <= right_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/single_rectangle_detector.sv
// Top level of the single rectangle detector.
`timescale 1ns / 1ps
`default_nettype none

// Takes one binary pixel per request in raster order (1 black) and, on the
// last pixel of each frame, returns one verdict: no black pixel, exactly one
// solid axis-aligned rectangle (with its top, left, bottom and right), or
// anything else; coordinates read zero unless a rectangle is found. Frame
// size comes from image_rows and image_cols (index 0 and 1, reset 1; zero acts
// as one and anything above 1024 as 1024). A pixel is taken every clock while
// req_stall is low and held in the input register; when the last pixel of a
// frame moves on, its verdict is loaded into the result register. The pixel
// pipeline holds only while a verdict waits in the result register under stall.
module single_rectangle_detector
   import srd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_pixel_black,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [ROW_W-1:0]          rsp_top_row,
   output logic [COL_W-1:0]          rsp_left_col,
   output logic [ROW_W-1:0]          rsp_bottom_row,
   output logic [COL_W-1:0]          rsp_right_col,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_wdata
);

   frame_size_type frame_size;
   result_type     result;
   logic           frame_end;
   logic           advance;

   logic           pix_valid_ff;
   logic           pix_ff;
   logic           rsp_valid_ff;
   result_type     rsp_ff;

   assign csr_ready = 1'b1;

   srd_cfg u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .frame_size (frame_size)
   );

   srd_track u_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .pixel_black (pix_ff),
      .frame_size  (frame_size),
      .frame_end   (frame_end),
      .result      (result)
   );

   // Move the held pixel on whenever the result register can take a verdict
   assign advance   = pix_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pix_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         pix_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         pix_ff <= req_pixel_black;
      end
   end

   // Result register: load on the last pixel, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && frame_end) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_top_row    = rsp_ff.top_row;
   assign rsp_left_col   = rsp_ff.left_col;
   assign rsp_bottom_row = rsp_ff.bottom_row;
   assign rsp_right_col  = rsp_ff.right_col;

   // Coordinates are zero unless a rectangle was found
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_RECT) |->
         (rsp_top_row == '0 && rsp_left_col == '0 &&
          rsp_bottom_row == '0 && rsp_right_col == '0))
      else $error("coordinates set without a rectangle");

   // A reported rectangle is never inverted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_RECT) |->
         (rsp_top_row <= rsp_bottom_row && rsp_left_col <= rsp_right_col))
      else $error("inverted rectangle reported");

   // A held pixel is lost only when it advances into the tracker
   assert property (@(posedge clock) disable iff (reset)
      (pix_valid_ff && !advance) |=> pix_valid_ff)
      else $error("pixel dropped from input register");

   // A verdict is never overwritten while it waits under stall
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("waiting verdict overwritten");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench of the single rectangle detector.
`timescale 1ns / 1ps

module testbench;
   import srd_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 10;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_PIXELS = 780;
   localparam int IDLE_MAX      = 5;

   // Indexes beyond the two registers, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      STEP_PIXEL,
      STEP_WRITE,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type       kind;
      logic                black;
      logic [CSR_IDX_W-1:0] index;
      logic [SIZE_W-1:0]   data;
      bit                  calm;
   } scan_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_pixel_black = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [ROW_W-1:0]     rsp_top_row;
   logic [COL_W-1:0]     rsp_left_col;
   logic [ROW_W-1:0]     rsp_bottom_row;
   logic [COL_W-1:0]     rsp_right_col;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_wdata = '0;

   // Pixels and register writes still to send, and verdicts still owed
   scan_step_type frame_script[$];
   result_type    pending_verdicts[$];

   // Predicted frame state and register copies
   logic [SIZE_W-1:0] size_rows = SIZE_W'(1);
   logic [SIZE_W-1:0] size_cols = SIZE_W'(1);
   int  scan_row = 0;
   int  scan_col = 0;
   bit  any_black = 0;
   int  box_top = 0;
   int  box_left = 0;
   int  box_bottom = 0;
   int  box_right = 0;
   int  black_total = 0;

   // Handshake bookkeeping shared by driver, receiver and monitor
   bit            req_done = 0;
   bit            csr_done = 0;
   bit            rsp_done = 0;
   bit            sending = 0;
   bit            calm_mode = 0;
   bit            gen_calm = 0;
   int            gap_left = 0;
   int            stall_left = 0;
   int            quiet_cycles = 0;
   int            fault_count = 0;
   int            cycle_count = 0;
   scan_step_type current;

   single_rectangle_detector dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_black (req_pixel_black),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_top_row     (rsp_top_row),
      .rsp_left_col    (rsp_left_col),
      .rsp_bottom_row  (rsp_bottom_row),
      .rsp_right_col   (rsp_right_col),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Advance the bounding box by one pixel and owe a verdict at frame end
   task automatic track_pixel(input logic black);
      int         rows_eff;
      int         cols_eff;
      bit         row_end;
      result_type verdict;
      rows_eff = (size_rows == 0) ? 1 : (size_rows > MAX_ROWS) ? MAX_ROWS : int'(size_rows);
      cols_eff = (size_cols == 0) ? 1 : (size_cols > MAX_COLS) ? MAX_COLS : int'(size_cols);
      if (black) begin
         if (!any_black) begin
            any_black = 1;
            box_top = scan_row;
            box_bottom = scan_row;
            box_left = scan_col;
            box_right = scan_col;
         end else begin
            if (scan_col < box_left) box_left = scan_col;
            if (scan_col > box_right) box_right = scan_col;
            if (scan_row > box_bottom) box_bottom = scan_row;
         end
         black_total++;
      end
      row_end = scan_col >= cols_eff - 1;
      if (row_end && scan_row >= rows_eff - 1) begin
         verdict.status = STATUS_NONE;
         verdict.top_row = '0;
         verdict.left_col = '0;
         verdict.bottom_row = '0;
         verdict.right_col = '0;
         if (any_black) begin
            if ((box_bottom - box_top + 1) * (box_right - box_left + 1) == black_total) begin
               verdict.status = STATUS_RECT;
               verdict.top_row = ROW_W'(box_top);
               verdict.left_col = COL_W'(box_left);
               verdict.bottom_row = ROW_W'(box_bottom);
               verdict.right_col = COL_W'(box_right);
            end else begin
               verdict.status = STATUS_OTHER;
            end
         end
         pending_verdicts.push_back(verdict);
         scan_row = 0;
         scan_col = 0;
         any_black = 0;
         box_top = 0;
         box_left = 0;
         box_bottom = 0;
         box_right = 0;
         black_total = 0;
      end else if (row_end) begin
         scan_col = 0;
         scan_row++;
      end else begin
         scan_col++;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] wanted,
                              input logic [15:0] seen);
      if (seen !== wanted) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, wanted, seen);
         fault_count++;
      end
   endtask

   task automatic push_pixel(input logic black);
      scan_step_type step;
      step.kind = STEP_PIXEL;
      step.black = black;
      step.index = '0;
      step.data = '0;
      step.calm = gen_calm;
      frame_script.push_back(step);
   endtask

   task automatic push_write(input logic [CSR_IDX_W-1:0] index, input int data);
      scan_step_type step;
      step.kind = STEP_WRITE;
      step.black = 1'b0;
      step.index = index;
      step.data = SIZE_W'(data);
      step.calm = gen_calm;
      frame_script.push_back(step);
   endtask

   // Paint a box (empty when top > bottom), optionally invert one pixel or use noise
   task automatic push_frame(input int rows, input int cols, input int top, input int left,
                             input int bottom, input int right, input int flip,
                             input bit noisy);
      logic black;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            if (noisy)
               black = 1'($urandom_range(0, 1));
            else
               black = (r >= top && r <= bottom && c >= left && c <= right);
            if (r * cols + c == flip) black = ~black;
            push_pixel(black);
         end
      end
   endtask

   // Driver: present the next request or register write once the gap has run out
   always @(negedge clock) begin : drive
      scan_step_type head;
      if (!reset) begin
         if (req_done) begin
            req_done = 0;
            sending = 0;
         end
         if (csr_done) begin
            csr_done = 0;
            sending = 0;
         end
         if (!sending) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (frame_script.size() != 0) begin
               head = frame_script[0];
               // writes wait for an idle block, a drain only for the owed verdicts
               if (head.kind == STEP_PIXEL ||
                   (head.kind == STEP_WRITE && pending_verdicts.size() == 0 &&
                    quiet_cycles >= SETTLE_CYCLES)) begin
                  current = frame_script.pop_front();
                  sending = 1;
                  calm_mode = current.calm;
                  gap_left = current.calm ? 0 : $urandom_range(0, IDLE_MAX);
               end else if (head.kind == STEP_DRAIN && pending_verdicts.size() == 0) begin
                  void'(frame_script.pop_front());
               end
            end
         end
         req_valid <= sending && current.kind == STEP_PIXEL;
         req_pixel_black <= current.black;
         csr_valid <= sending && current.kind == STEP_WRITE;
         csr_index <= current.index;
         csr_wdata <= current.data;
      end
   end

   // Receiver: hold stall for a random stretch after each verdict
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_done) begin
            rsp_done = 0;
            stall_left = calm_mode ? 0 : $urandom_range(0, IDLE_MAX);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted verdict
   always @(posedge clock) begin : observe
      result_type due;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_done = 1;
            quiet_cycles = 0;
            track_pixel(req_pixel_black);
         end else if (quiet_cycles < SETTLE_CYCLES) begin
            quiet_cycles++;
         end
         if (csr_valid && csr_ready) begin
            csr_done = 1;
            case (csr_index)
               REG_IMAGE_ROWS: size_rows = csr_wdata;
               REG_IMAGE_COLS: size_cols = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_done = 1;
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, actual status %0d", $time,
                        rsp_status);
               fault_count++;
            end else begin
               due = pending_verdicts.pop_front();
               check_field("status", 16'(due.status), 16'(rsp_status));
               check_field("top_row", 16'(due.top_row), 16'(rsp_top_row));
               check_field("left_col", 16'(due.left_col), 16'(rsp_left_col));
               check_field("bottom_row", 16'(due.bottom_row), 16'(rsp_bottom_row));
               check_field("right_col", 16'(due.right_col), 16'(rsp_right_col));
            end
         end
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL single_rectangle_detector");
         $finish;
      end
   end

   initial begin : script
      int rows;
      int cols;
      int top;
      int left;
      int bottom;
      int right;
      int shape;
      int frames;
      int scripted;
      int phase;

      // Single-pixel frames at the reset size, then zero sizes acting as one
      push_pixel(1'b0);
      push_pixel(1'b1);
      push_write(REG_IMAGE_ROWS, 0);
      push_write(REG_IMAGE_COLS, 0);
      push_pixel(1'b1);
      // Writes to spare indexes leave the size alone
      push_write(REG_SPARE_A, 5);
      push_write(REG_SPARE_B, 2047);
      push_pixel(1'b0);
      // Full square with a hole in the middle
      push_write(REG_IMAGE_ROWS, 3);
      push_write(REG_IMAGE_COLS, 3);
      push_frame(3, 3, 0, 0, 2, 2, 4, 0);
      // Narrow the frame part way through: the last two rows become two wide
      push_pixel(1'b1);
      push_pixel(1'b0);
      push_pixel(1'b0);
      push_pixel(1'b1);
      push_write(REG_IMAGE_COLS, 2);
      push_pixel(1'b0);
      push_pixel(1'b1);
      push_pixel(1'b0);

      // Oversized row count, then shrink it part way through: a solid three by two
      push_write(REG_IMAGE_ROWS, 2047);
      push_write(REG_IMAGE_COLS, 2);
      push_frame(2, 2, 0, 0, 1, 1, -1, 0);
      push_write(REG_IMAGE_ROWS, 2);
      push_pixel(1'b1);
      push_pixel(1'b1);

      // Random phases on small frames, mostly boxes with some damage and noise
      scripted = 0;
      phase = 0;
      while (scripted < RANDOM_PIXELS) begin
         rows = $urandom_range(1, 6);
         cols = $urandom_range(1, 6);
         gen_calm = ($urandom_range(0, 3) == 0);
         push_write(REG_IMAGE_ROWS, (rows == 1 && $urandom_range(0, 1)) ? 0 : rows);
         push_write(REG_IMAGE_COLS, (cols == 1 && $urandom_range(0, 1)) ? 0 : cols);
         if ($urandom_range(0, 7) == 0)
            push_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                       $urandom_range(0, 2047));
         frames = $urandom_range(2, 8);
         for (int f = 0; f < frames; f++) begin
            top = $urandom_range(0, rows - 1);
            bottom = $urandom_range(top, rows - 1);
            left = $urandom_range(0, cols - 1);
            right = $urandom_range(left, cols - 1);
            shape = $urandom_range(0, 9);
            case (shape)
               4: push_frame(rows, cols, 1, 0, 0, cols - 1, -1, 0);
               5, 6: push_frame(rows, cols, top, left, bottom, right,
                                $urandom_range(0, rows * cols - 1), 0);
               7, 8: push_frame(rows, cols, 0, 0, 0, 0, -1, 1);
               9: push_frame(rows, cols, 0, 0, rows - 1, cols - 1, -1, 0);
               default: push_frame(rows, cols, top, left, bottom, right, -1, 0);
            endcase
            scripted += rows * cols;
            // hold the sender until every owed verdict is back
            if (phase == 3 && f == 0) begin
               frame_script.push_back('{STEP_DRAIN, 1'b0, '0, '0, gen_calm});
            end
         end
         phase++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (frame_script.size() != 0 || req_valid || csr_valid || pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_verdicts.size() == 0) begin
         $display("PASS single_rectangle_detector");
      end else begin
         $display("FAIL single_rectangle_detector");
      end
      $finish;
   end

endmodule
